>>> rtl/core/orb_pkg.sv
// Shared types and constants for the orthogonal recursive bisection block.
package orb_pkg;

    localparam int COORD_W = 32;
    localparam int DIMS_W  = 2;
    localparam int PART_W  = 11;
    localparam int RANK_W  = 10;
    localparam int IDX_W   = 10;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    // Round number stored per point; at most ten rounds, as the part count saturates at 1024.
    localparam int LVL_W   = 4;
    // Largest part count; the rank register holds ranks up to this value minus one.
    localparam int MAX_PARTS = 1024;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] REG_DIMS  = 2'd0;
    localparam logic [1:0] REG_PARTS = 2'd1;
    localparam logic [1:0] REG_RANK  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_BOX,
        ST_CUT,
        ST_DIV,
        ST_RANK_I,
        ST_RANK_LD,
        ST_RANK_J,
        ST_RANK_WR,
        ST_UPDATE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] point_index;
        logic             index_valid;
        logic             last_index;
        logic             overflow;
    } out_word_t;

endpackage

>>> rtl/core/orb_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module orb_divider #(
    parameter int DVD_W = 21,
    parameter int DIV_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Shift in the next dividend bit and subtract when the divisor fits.
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/orthogonal_recursive_bisection.sv
// Top level of the orthogonal recursive bisection block.
// The input channel (in_valid, in_ready, in_word) carries one word per operation:
// load a point, read the next index of the own part, or clear the point set.
// The output channel (out_valid, out_ready, out_word) returns one word for each
// read and for each load that was dropped because the point memory is full.
// A read of an already partitioned set scans the mark memory from the read
// pointer, one entry per cycle. The first read after any stored load, clear or
// register write first runs the partition: a mark sweep, then per bisection
// round a bounding-box pass, a choice of cut dimension, a serial divide, a rank
// pass and an update of the active set, all bounded by the single read port of
// the coordinate and mark memories. Reset empties the point set, sets one
// dimension, one part and rank zero. The memories are not cleared; every entry
// that matters is written first. A result sits in an output register; while
// the receiver stalls, the block finishes the current operation and then holds
// in_ready low until the result is taken. Registers are to be written over the
// APB port only while the block is idle; the block does not enforce this.
module orthogonal_recursive_bisection #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  orb_pkg::in_word_t              in_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output orb_pkg::out_word_t             out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [orb_pkg::PADDR_W-1:0]    paddr,
    input  logic [orb_pkg::PDATA_W-1:0]    pwdata,
    output logic [orb_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CW    = orb_pkg::COORD_W;
    localparam int MW    = CW * MAX_DIMS;
    localparam int DVD_W = CNT_W + orb_pkg::RANK_W;

    // Point storage and the per-point round mark (last round survived).
    logic [MW-1:0]               coord_mem [MAX_POINTS];
    logic [orb_pkg::LVL_W-1:0]   level_mem [MAX_POINTS];
    logic [MW-1:0]               coord_q_reg;
    logic [orb_pkg::LVL_W-1:0]   level_q_reg;
    logic [AW-1:0]               rd_addr;
    logic                        coord_we;
    logic [MW-1:0]               coord_wdata;
    logic                        level_we;
    logic [AW-1:0]               level_waddr;
    logic [orb_pkg::LVL_W-1:0]   level_wdata;

    orb_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]            total_reg, total_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            rptr_reg, rptr_next;
    logic [orb_pkg::DIMS_W-1:0]  dims_cfg_reg, dims_cfg_next;
    logic [orb_pkg::PART_W-1:0]  parts_cfg_reg, parts_cfg_next;
    logic [orb_pkg::RANK_W-1:0]  rank_cfg_reg, rank_cfg_next;
    logic [orb_pkg::PART_W-1:0]  parts_reg, parts_next;
    logic [orb_pkg::RANK_W-1:0]  rank_reg, rank_next;
    logic [CNT_W-1:0]            n_reg, n_next;
    logic [orb_pkg::LVL_W-1:0]   round_reg, round_next;
    logic [1:0]                  cut_reg, cut_next;
    logic signed [CW-1:0]        lo_reg [MAX_DIMS];
    logic signed [CW-1:0]        lo_next [MAX_DIMS];
    logic signed [CW-1:0]        hi_reg [MAX_DIMS];
    logic signed [CW-1:0]        hi_next [MAX_DIMS];
    logic                        first_reg, first_next;
    logic [CNT_W-1:0]            keep_reg, keep_next;
    logic [CNT_W-1:0]            ia_reg, ia_next;
    logic                        pv_reg, pv_next;
    logic [CNT_W-1:0]            pidx_reg, pidx_next;
    logic [CNT_W-1:0]            i_reg, i_next;
    logic signed [CW-1:0]        ci_reg, ci_next;
    logic [CNT_W-1:0]            below_reg, below_next;
    logic [CNT_W-1:0]            found_reg, found_next;
    logic                        ffound_reg, ffound_next;
    logic                        out_valid_reg, out_valid_next;
    orb_pkg::out_word_t          out_word_reg, out_word_next;

    logic                        in_fire;
    logic                        cfg_wr;
    logic [orb_pkg::DIMS_W-1:0]  dims_eff;
    logic [orb_pkg::PART_W-1:0]  parts_eff;
    logic [orb_pkg::RANK_W-1:0]  rank_eff;
    logic [orb_pkg::RANK_W-1:0]  half;
    logic                        go_low_side;
    logic                        q_active;
    logic                        q_final;
    logic signed [CW-1:0]        q_cut;
    logic signed [CW:0]          extent [MAX_DIMS];
    logic                        div_start;
    logic                        div_done;
    logic [DVD_W-1:0]            div_quo;
    logic [DVD_W-1:0]            div_dividend;
    logic                        issue_ok;

    assign in_ready = (state_reg == orb_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // Register values as the partition uses them, saturated into range.
    always_comb
    begin
        if (dims_cfg_reg == '0)
            dims_eff = orb_pkg::DIMS_W'(1);
        else if (int'(dims_cfg_reg) > MAX_DIMS)
            dims_eff = orb_pkg::DIMS_W'(MAX_DIMS);
        else
            dims_eff = dims_cfg_reg;
        if (parts_cfg_reg == '0)
            parts_eff = orb_pkg::PART_W'(1);
        else if (int'(parts_cfg_reg) > orb_pkg::MAX_PARTS)
            parts_eff = orb_pkg::PART_W'(orb_pkg::MAX_PARTS);
        else
            parts_eff = parts_cfg_reg;
        if ({1'b0, rank_cfg_reg} >= parts_eff)
            rank_eff = orb_pkg::RANK_W'(parts_eff - 1'b1);
        else
            rank_eff = rank_cfg_reg;
    end

    assign half         = parts_reg[orb_pkg::PART_W-1:1];
    assign go_low_side  = (rank_reg < half);
    assign q_active     = (level_q_reg >= round_reg);
    assign q_final      = (level_q_reg == round_reg);
    assign q_cut        = coord_q_reg[CW*cut_reg +: CW];
    assign issue_ok     = (ia_reg < total_reg);
    assign div_dividend = DVD_W'(n_reg) * DVD_W'(half);

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            extent[d] = {hi_reg[d][CW-1], hi_reg[d]} - {lo_reg[d][CW-1], lo_reg[d]};
        end
    end

    orb_divider #(
        .DVD_W (DVD_W),
        .DIV_W (orb_pkg::PART_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (parts_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            orb_pkg::ST_IDLE:
            begin
                if (in_fire && in_word.operation == orb_pkg::OP_READ)
                    state_next = done_reg ? orb_pkg::ST_SCAN : orb_pkg::ST_INIT;
            end
            orb_pkg::ST_INIT:
            begin
                if (!issue_ok)
                    state_next = orb_pkg::ST_ROUND;
            end
            orb_pkg::ST_ROUND:
            begin
                if (parts_reg > orb_pkg::PART_W'(1) && n_reg != '0)
                    state_next = orb_pkg::ST_BOX;
                else
                    state_next = orb_pkg::ST_SCAN;
            end
            orb_pkg::ST_BOX:
            begin
                if (!issue_ok && !pv_reg)
                    state_next = orb_pkg::ST_CUT;
            end
            orb_pkg::ST_CUT:    state_next = orb_pkg::ST_DIV;
            orb_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = orb_pkg::ST_RANK_I;
            end
            orb_pkg::ST_RANK_I:
            begin
                state_next = (i_reg < total_reg) ? orb_pkg::ST_RANK_LD : orb_pkg::ST_UPDATE;
            end
            orb_pkg::ST_RANK_LD:
            begin
                state_next = q_active ? orb_pkg::ST_RANK_J : orb_pkg::ST_RANK_I;
            end
            orb_pkg::ST_RANK_J:
            begin
                if (!issue_ok && !pv_reg)
                    state_next = orb_pkg::ST_RANK_WR;
            end
            orb_pkg::ST_RANK_WR: state_next = orb_pkg::ST_RANK_I;
            orb_pkg::ST_UPDATE:  state_next = orb_pkg::ST_ROUND;
            orb_pkg::ST_SCAN:
            begin
                if ((pv_reg && q_final && ffound_reg) || (!issue_ok && !pv_reg))
                    state_next = orb_pkg::ST_IDLE;
            end
            default:             state_next = orb_pkg::ST_IDLE;
        endcase
    end

    // Memory and divider controls.
    always_comb
    begin
        rd_addr     = ia_reg[AW-1:0];
        coord_we    = 1'b0;
        level_we    = 1'b0;
        level_waddr = ia_reg[AW-1:0];
        level_wdata = '0;
        div_start   = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            case (d)
                0:       coord_wdata[CW*d +: CW] = in_word.coord_x;
                1:       coord_wdata[CW*d +: CW] = in_word.coord_y;
                default: coord_wdata[CW*d +: CW] = in_word.coord_z;
            endcase
        end
        case (state_reg)
            orb_pkg::ST_IDLE:
            begin
                coord_we = in_fire && in_word.operation == orb_pkg::OP_LOAD &&
                           total_reg < CNT_W'(MAX_POINTS);
            end
            orb_pkg::ST_INIT:
            begin
                level_we = issue_ok;
            end
            orb_pkg::ST_CUT:
            begin
                div_start = 1'b1;
            end
            orb_pkg::ST_RANK_I:
            begin
                rd_addr = i_reg[AW-1:0];
            end
            orb_pkg::ST_RANK_WR:
            begin
                // Survivors of this round are marked with the next round number.
                level_waddr = i_reg[AW-1:0];
                level_wdata = round_reg + 1'b1;
                level_we    = ((below_reg < keep_reg) == go_low_side);
            end
            default:
            begin
                level_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        total_next     = total_reg;
        done_next      = done_reg;
        rptr_next      = rptr_reg;
        dims_cfg_next  = dims_cfg_reg;
        parts_cfg_next = parts_cfg_reg;
        rank_cfg_next  = rank_cfg_reg;
        parts_next     = parts_reg;
        rank_next      = rank_reg;
        n_next         = n_reg;
        round_next     = round_reg;
        cut_next       = cut_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        keep_next      = keep_reg;
        ia_next        = ia_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        i_next         = i_reg;
        ci_next        = ci_reg;
        below_next     = below_reg;
        found_next     = found_reg;
        ffound_next    = ffound_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        if (cfg_wr && paddr[3:2] <= orb_pkg::REG_RANK)
        begin
            case (paddr[3:2])
                orb_pkg::REG_DIMS:  dims_cfg_next  = pwdata[orb_pkg::DIMS_W-1:0];
                orb_pkg::REG_PARTS: parts_cfg_next = pwdata[orb_pkg::PART_W-1:0];
                default:            rank_cfg_next  = pwdata[orb_pkg::RANK_W-1:0];
            endcase
            done_next = 1'b0;
            rptr_next = '0;
        end

        case (state_reg)
            orb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_word.operation)
                        orb_pkg::OP_LOAD:
                        begin
                            if (total_reg >= CNT_W'(MAX_POINTS))
                            begin
                                out_valid_next         = 1'b1;
                                out_word_next          = '0;
                                out_word_next.overflow = 1'b1;
                            end
                            else
                            begin
                                total_next = total_reg + 1'b1;
                                done_next  = 1'b0;
                                rptr_next  = '0;
                            end
                        end
                        orb_pkg::OP_CLEAR:
                        begin
                            total_next = '0;
                            done_next  = 1'b0;
                            rptr_next  = '0;
                        end
                        orb_pkg::OP_READ:
                        begin
                            pv_next     = 1'b0;
                            ffound_next = 1'b0;
                            if (done_reg)
                                ia_next = rptr_reg;
                            else
                            begin
                                ia_next    = '0;
                                round_next = '0;
                                parts_next = parts_eff;
                                rank_next  = rank_eff;
                                n_next     = total_reg;
                            end
                        end
                        default:
                        begin
                            pv_next = 1'b0;
                        end
                    endcase
                end
            end
            orb_pkg::ST_INIT:
            begin
                if (issue_ok)
                    ia_next = ia_reg + 1'b1;
            end
            orb_pkg::ST_ROUND:
            begin
                ia_next     = '0;
                pv_next     = 1'b0;
                first_next  = 1'b1;
                ffound_next = 1'b0;
                if (!(parts_reg > orb_pkg::PART_W'(1) && n_reg != '0))
                begin
                    done_next = 1'b1;
                    rptr_next = '0;
                end
            end
            orb_pkg::ST_BOX:
            begin
                pv_next   = issue_ok;
                pidx_next = ia_reg;
                if (issue_ok)
                    ia_next = ia_reg + 1'b1;
                if (pv_reg && q_active)
                begin
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        if (d < int'(dims_eff))
                        begin
                            if (first_reg || $signed(coord_q_reg[CW*d +: CW]) < lo_reg[d])
                                lo_next[d] = coord_q_reg[CW*d +: CW];
                            if (first_reg || $signed(coord_q_reg[CW*d +: CW]) > hi_reg[d])
                                hi_next[d] = coord_q_reg[CW*d +: CW];
                        end
                    end
                    first_next = 1'b0;
                end
            end
            orb_pkg::ST_CUT:
            begin
                // Widest extent wins; the lower dimension keeps a tie.
                cut_next = '0;
                for (int d = 1; d < MAX_DIMS; d++)
                begin
                    if (d < int'(dims_eff) && extent[d] > extent[int'(cut_next)])
                        cut_next = 2'(d);
                end
            end
            orb_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    keep_next = div_quo[CNT_W-1:0];
                    i_next    = '0;
                end
            end
            orb_pkg::ST_RANK_LD:
            begin
                if (q_active)
                begin
                    ci_next    = q_cut;
                    ia_next    = '0;
                    pv_next    = 1'b0;
                    below_next = '0;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            orb_pkg::ST_RANK_J:
            begin
                pv_next   = issue_ok;
                pidx_next = ia_reg;
                if (issue_ok)
                    ia_next = ia_reg + 1'b1;
                if (pv_reg && q_active &&
                    (q_cut < ci_reg || (q_cut == ci_reg && pidx_reg < i_reg)))
                    below_next = below_reg + 1'b1;
            end
            orb_pkg::ST_RANK_WR:
            begin
                i_next = i_reg + 1'b1;
            end
            orb_pkg::ST_UPDATE:
            begin
                if (go_low_side)
                begin
                    n_next     = keep_reg;
                    parts_next = {1'b0, half};
                end
                else
                begin
                    n_next     = n_reg - keep_reg;
                    parts_next = parts_reg - {1'b0, half};
                    rank_next  = rank_reg - half;
                end
                round_next = round_reg + 1'b1;
            end
            orb_pkg::ST_SCAN:
            begin
                pv_next   = issue_ok;
                pidx_next = ia_reg;
                if (issue_ok)
                    ia_next = ia_reg + 1'b1;
                if (pv_reg && q_final)
                begin
                    if (!ffound_reg)
                    begin
                        found_next  = pidx_reg;
                        ffound_next = 1'b1;
                    end
                    else
                    begin
                        // A second member exists, so the found one is not the last.
                        out_valid_next            = 1'b1;
                        out_word_next             = '0;
                        out_word_next.point_index = orb_pkg::IDX_W'(found_reg);
                        out_word_next.index_valid = 1'b1;
                        rptr_next                 = found_reg + 1'b1;
                    end
                end
                else if (!issue_ok && !pv_reg)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    if (ffound_reg)
                    begin
                        out_word_next.point_index = orb_pkg::IDX_W'(found_reg);
                        out_word_next.index_valid = 1'b1;
                        out_word_next.last_index  = 1'b1;
                        rptr_next                 = found_reg + 1'b1;
                    end
                    else
                        rptr_next = total_reg;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (coord_we)
            coord_mem[total_reg[AW-1:0]] <= coord_wdata;
        if (level_we)
            level_mem[level_waddr] <= level_wdata;
        coord_q_reg <= coord_mem[rd_addr];
        level_q_reg <= level_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= orb_pkg::ST_IDLE;
            total_reg     <= '0;
            done_reg      <= 1'b0;
            rptr_reg      <= '0;
            dims_cfg_reg  <= orb_pkg::DIMS_W'(1);
            parts_cfg_reg <= orb_pkg::PART_W'(1);
            rank_cfg_reg  <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            ffound_reg    <= 1'b0;
            first_reg     <= 1'b1;
            ia_reg        <= '0;
            i_reg         <= '0;
            round_reg     <= '0;
            parts_reg     <= orb_pkg::PART_W'(1);
            rank_reg      <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
            rptr_reg      <= rptr_next;
            dims_cfg_reg  <= dims_cfg_next;
            parts_cfg_reg <= parts_cfg_next;
            rank_cfg_reg  <= rank_cfg_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= pv_next;
            ffound_reg    <= ffound_next;
            first_reg     <= first_next;
            ia_reg        <= ia_next;
            i_reg         <= i_next;
            round_reg     <= round_next;
            parts_reg     <= parts_next;
            rank_reg      <= rank_next;
            n_reg         <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg      <= cut_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        keep_reg     <= keep_next;
        pidx_reg     <= pidx_next;
        ci_reg       <= ci_next;
        below_reg    <= below_next;
        found_reg    <= found_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        case (paddr[3:2])
            orb_pkg::REG_DIMS:  prdata = orb_pkg::PDATA_W'(dims_cfg_reg);
            orb_pkg::REG_PARTS: prdata = orb_pkg::PDATA_W'(parts_cfg_reg);
            orb_pkg::REG_RANK:  prdata = orb_pkg::PDATA_W'(rank_cfg_reg);
            default:            prdata = '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The point count never passes the memory depth.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond memory depth");

    // A round only starts with at least two parts left.
    a_cut_parts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == orb_pkg::ST_CUT |-> parts_reg > orb_pkg::PART_W'(1))
        else $error("bisection round with a single part");

    // The lower part never keeps more points than the active set holds.
    a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == orb_pkg::ST_RANK_I && $past(state_reg) == orb_pkg::ST_DIV)
        |-> keep_reg <= n_reg)
        else $error("lower part larger than active set");

endmodule

>>> tb/sv/orb_checker.sv
// Checker for the orthogonal recursive bisection block: predicts result words and compares them.
module orb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  orb_pkg::in_word_t            in_word,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  orb_pkg::out_word_t           out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [orb_pkg::PADDR_W-1:0]  paddr,
    input  logic [orb_pkg::PDATA_W-1:0]  pwdata,
    output int                           fail_count,
    output int                           pending,
    output int                           words_seen
);

    localparam int POINT_CAP = 1024;
    localparam int PART_CAP  = 1024;

    longint                       coords [POINT_CAP][3];
    bit                           in_part [POINT_CAP];
    bit                           lower_half [POINT_CAP];
    int unsigned                  point_total;
    int unsigned                  read_ptr;
    bit                           split_done;
    logic [orb_pkg::DIMS_W-1:0]   dims_reg;
    logic [orb_pkg::PART_W-1:0]   parts_reg;
    logic [orb_pkg::RANK_W-1:0]   rank_reg;
    orb_pkg::out_word_t           expected_words [$];

    task automatic report(input string what);
        $display("orb_checker: %s at %0t", what, $realtime);
        fail_count++;
    endtask

    // Splits the loaded points until one part or no point remains and marks the own part.
    function automatic void bisect_points();
        int unsigned dims, parts, rank, n, cut, half, i, j, d;
        longint lo [3], hi [3], best, keep, below;
        bit first;
        dims  = (dims_reg == 0) ? 1 : dims_reg;
        parts = (parts_reg == 0) ? 1 : ((parts_reg > PART_CAP) ? PART_CAP : parts_reg);
        rank  = (rank_reg >= parts) ? parts - 1 : rank_reg;
        n = point_total;
        for (i = 0; i < point_total; i++) in_part[i] = 1;
        while (parts > 1 && n > 0) begin
            first = 1;
            cut = 0;
            for (i = 0; i < point_total; i++) begin
                if (in_part[i]) begin
                    for (d = 0; d < dims; d++) begin
                        if (first || coords[i][d] < lo[d]) lo[d] = coords[i][d];
                        if (first || coords[i][d] > hi[d]) hi[d] = coords[i][d];
                    end
                    first = 0;
                end
            end
            best = hi[0] - lo[0];
            for (d = 1; d < dims; d++) begin
                if (hi[d] - lo[d] > best) begin
                    best = hi[d] - lo[d];
                    cut = d;
                end
            end
            half = parts / 2;
            keep = (longint'(n) * half) / parts;
            for (i = 0; i < point_total; i++) begin
                lower_half[i] = 0;
                if (in_part[i]) begin
                    below = 0;
                    for (j = 0; j < point_total; j++) begin
                        if (in_part[j] && (coords[j][cut] < coords[i][cut] ||
                            (coords[j][cut] == coords[i][cut] && j < i)))
                            below++;
                    end
                    lower_half[i] = (below < keep);
                end
            end
            if (rank < half) begin
                for (i = 0; i < point_total; i++)
                    if (in_part[i] && !lower_half[i]) in_part[i] = 0;
                n = keep;
                parts = half;
            end
            else begin
                for (i = 0; i < point_total; i++)
                    if (in_part[i] && lower_half[i]) in_part[i] = 0;
                n = n - keep;
                parts = parts - half;
                rank = rank - half;
            end
        end
        split_done = 1;
        read_ptr = 0;
    endfunction

    function automatic void predict_word(input orb_pkg::in_word_t w);
        orb_pkg::out_word_t r;
        int unsigned i, found, next;
        r = '0;
        case (w.operation)
            orb_pkg::OP_LOAD:
            begin
                if (point_total >= POINT_CAP) begin
                    r.overflow = 1;
                    expected_words.push_back(r);
                end
                else begin
                    coords[point_total][0] = longint'(w.coord_x);
                    coords[point_total][1] = longint'(w.coord_y);
                    coords[point_total][2] = longint'(w.coord_z);
                    point_total++;
                    split_done = 0;
                    read_ptr = 0;
                end
            end
            orb_pkg::OP_CLEAR:
            begin
                point_total = 0;
                split_done = 0;
                read_ptr = 0;
            end
            orb_pkg::OP_READ:
            begin
                if (!split_done) bisect_points();
                found = point_total;
                for (i = read_ptr; i < point_total; i++)
                    if (in_part[i] && found == point_total) found = i;
                if (found >= point_total) begin
                    read_ptr = point_total;
                end
                else begin
                    next = point_total;
                    for (i = found + 1; i < point_total; i++)
                        if (in_part[i] && next == point_total) next = i;
                    read_ptr = found + 1;
                    r.point_index = found[orb_pkg::IDX_W-1:0];
                    r.index_valid = 1;
                    r.last_index  = (next >= point_total);
                end
                expected_words.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            point_total = 0;
            read_ptr    = 0;
            split_done  = 0;
            dims_reg    = 1;
            parts_reg   = 1;
            rank_reg    = 0;
            expected_words.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[orb_pkg::PADDR_W-1:2])
                    orb_pkg::REG_DIMS:  dims_reg  = pwdata[orb_pkg::DIMS_W-1:0];
                    orb_pkg::REG_PARTS: parts_reg = pwdata[orb_pkg::PART_W-1:0];
                    orb_pkg::REG_RANK:  rank_reg  = pwdata[orb_pkg::RANK_W-1:0];
                    default:   ;
                endcase
                split_done = 0;
                read_ptr = 0;
            end
            if (out_valid && out_ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    report("result word with nothing expected");
                end
                else begin
                    orb_pkg::out_word_t e;
                    e = expected_words.pop_front();
                    if (out_word.point_index !== e.point_index)
                        report($sformatf("point_index %0d, expected %0d",
                                         out_word.point_index, e.point_index));
                    if (out_word.index_valid !== e.index_valid)
                        report($sformatf("index_valid %b, expected %b",
                                         out_word.index_valid, e.index_valid));
                    if (out_word.last_index !== e.last_index)
                        report($sformatf("last_index %b, expected %b",
                                         out_word.last_index, e.last_index));
                    if (out_word.overflow !== e.overflow)
                        report($sformatf("overflow %b, expected %b",
                                         out_word.overflow, e.overflow));
                end
            end
            if (in_valid && in_ready) predict_word(in_word);
        end
        pending = expected_words.size();
    end

    initial
    begin
        fail_count = 0;
        pending    = 0;
        words_seen = 0;
    end

endmodule

>>> tb/sv/tb_orthogonal_recursive_bisection.sv
// Top of the testbench for the orthogonal recursive bisection block: stimulus and verdict.
module tb_orthogonal_recursive_bisection;

    // The fourth operation code is not defined; the block must ignore it.
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 300;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    orb_pkg::in_word_t            in_word;
    logic                         out_valid;
    logic                         out_ready;
    orb_pkg::out_word_t           out_word;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [orb_pkg::PADDR_W-1:0]  paddr;
    logic [orb_pkg::PDATA_W-1:0]  pwdata;
    logic [orb_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    int fail_count;
    int pending;
    int words_seen;
    int words_sent;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_asked;
    int hold_given;
    int config_writes;

    orthogonal_recursive_bisection DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    orb_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
    );

    always #10 clk = ~clk;

    // Watchdog: the slowest correct run stays far below this many cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("orthogonal_recursive_bisection: mismatch");
            $finish;
        end
    end

    // Receiver. It stalls at random, and when the stimulus asks for it, it
    // holds off for a long stretch so the output register fills and the block
    // must drop in_ready while the sender keeps offering words.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_given < hold_asked) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_given++;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offers one word and waits for its handshake. Valid stays high after
    // acceptance so that back-to-back words never lower and raise it in one step.
    task automatic send_word(input logic [1:0] op, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        orb_pkg::in_word_t w;
        w.operation = op;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        forever
        begin
            @(posedge clk);
            if (in_ready) break;
        end
        words_sent++;
    endtask

    // Coordinates come from the full range, from a tiny range that forces
    // ties, or from the two extremes.
    function automatic logic [31:0] pick_coord(input int style);
        logic [31:0] c;
        case (style)
            0:       c = $urandom;
            1:       c = $urandom_range(0, 3) - 1;
            default: c = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
        return c;
    endfunction

    task automatic load_point(input int style);
        send_word(orb_pkg::OP_LOAD, pick_coord(style), pick_coord(style), pick_coord(style));
    endtask

    task automatic read_word();
        send_word(orb_pkg::OP_READ, $urandom, $urandom, $urandom);
    endtask

    // Waits until every expected word is back, then lets a dropped-free load
    // or clear finish inside the block.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Register writes only happen with the block idle: drain first.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= orb_pkg::PADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
    endtask

    task automatic setup(input int dims, input int parts, input int rank);
        write_reg(orb_pkg::REG_DIMS, dims);
        write_reg(orb_pkg::REG_PARTS, parts);
        write_reg(orb_pkg::REG_RANK, rank);
    endtask

    // One group: a fresh set of points, then a random number of reads, up to two
    // more than the points loaded, with the odd stray word mixed in.
    task automatic random_group();
        int k, reads, style;
        k = $urandom_range(0, 20);
        style = $urandom_range(0, 2);
        send_word(orb_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
        for (int i = 0; i < k; i++) load_point(($urandom_range(0, 3) == 0) ? 2 : style);
        reads = $urandom_range(1, k + 2);
        for (int i = 0; i < reads; i++)
        begin
            case ($urandom_range(0, 19))
                0:       send_word(OP_IGNORED, $urandom, $urandom, $urandom);
                1:       load_point(style);
                default: read_word();
            endcase
        end
    endtask

    task automatic random_config();
        int parts;
        case ($urandom_range(0, 5))
            0:       parts = 1;
            1:       parts = $urandom_range(2, 8);
            2:       parts = 1024;
            3:       parts = 2047;
            4:       parts = 0;
            default: parts = $urandom_range(1, 2047);
        endcase
        setup($urandom_range(0, 3), parts, $urandom_range(0, 1023));
    endtask

    task automatic random_phase(input int items);
        int target;
        target = words_sent + items;
        while (words_sent < target)
        begin
            if ($urandom_range(0, 2) == 0) random_config();
            random_group();
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        words_sent = 0;
        hold_asked = 0;
        hold_given = 0;
        config_writes = 0;
        send_idle_pct = 9;
        recv_idle_pct = 48;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a read of the empty set at reset settings, then extreme
        // coordinates in three dimensions split four ways, every operation,
        // the undefined operation, and a read after a clear.
        read_word();
        setup(3, 4, 3);
        send_word(orb_pkg::OP_LOAD, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
        send_word(orb_pkg::OP_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
        send_word(orb_pkg::OP_LOAD, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
        send_word(orb_pkg::OP_LOAD, 32'hffff_ffff, 32'h5555_5555, 32'h7fff_ffff);
        send_word(orb_pkg::OP_LOAD, 32'haaaa_aaaa, 32'h0000_0001, 32'h0000_0000);
        send_word(OP_IGNORED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        repeat (3) read_word();
        send_word(orb_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
        read_word();
        // Rank at or above the part count saturates; dimension zero acts as one.
        setup(0, 3, 1023);
        for (int i = 0; i < 4; i++) load_point(1);
        repeat (3) read_word();

        random_phase(200);

        // Second idle mix, and a long receiver hold while reads keep coming.
        drain();
        send_idle_pct = 48;
        recv_idle_pct = 9;
        random_phase(200);
        setup(2, 1, 0);
        send_word(orb_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++) load_point(0);
        send_idle_pct = 0;
        hold_asked++;
        repeat (12) read_word();

        // Neither side idles.
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);
        send_word(orb_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0);
        read_word();

        drain();
        $display("Sent %0d words over %0d register writes, checked %0d result words.",
                 words_sent, config_writes, words_seen);
        $display("Covered loads, reads, clears, ignored words, long stalls and sender pauses.");
        if (fail_count == 0)
            $display("orthogonal_recursive_bisection: match");
        else
            $display("orthogonal_recursive_bisection: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/orb_pkg.sv
rtl/core/orb_divider.sv
rtl/core/orthogonal_recursive_bisection.sv
tb/sv/orb_checker.sv
tb/sv/tb_orthogonal_recursive_bisection.sv
